@@ hw/rtl/cpu6502_pkg.sv @@
// ----------------------------------------------------------------------------
// cpu6502_pkg
// Shared types, codes and the opcode decoder of the 6502 subset core.
// ----------------------------------------------------------------------------
package cpu6502_pkg;

  localparam int MEM_BYTES = 65536;

  localparam logic [15:0] PC_RESET = 16'hFFFC;
  localparam logic [7:0]  SP_RESET = 8'hFF;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_EXEC  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_HWR, ST_HRD, ST_HRD_WAIT, ST_FETCH, ST_OPC, ST_DECODE,
    ST_AD2, ST_AD3, ST_PTR1, ST_PTR2, ST_OPER, ST_EXEC, ST_PULL, ST_PULL_EXEC,
    ST_BR, ST_JSR2, ST_JSR3, ST_JSR4, ST_RTS1, ST_RTS2, ST_RTS3, ST_JMP2,
    ST_JMP3, ST_JI1, ST_JI2, ST_JI3, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY
  } mode_t;

  typedef enum logic [3:0] {
    K_LOAD, K_STORE, K_ORA, K_AND, K_EOR, K_IMPL, K_PHA, K_PHP, K_PLA, K_PLP,
    K_BEQ, K_JSR, K_RTS, K_JMP, K_JMPI, K_UNK
  } kind_t;

  typedef enum logic [4:0] {
    R_NONE, R_TAX, R_TAY, R_TXA, R_TYA, R_TSX, R_TXS, R_INX, R_INY, R_DEX,
    R_DEY, R_LDA, R_LDX, R_LDY, R_ORA, R_AND, R_EOR, R_PLA, R_PLP
  } rop_t;

  typedef enum logic [2:0] {
    A_PC, A_EA, A_EA1, A_STACK, A_ZPTR, A_ZPTR1, A_HOST, A_CLR
  } asel_t;

  typedef enum logic [2:0] {
    W_ACC, W_X, W_Y, W_P, W_PCH, W_PCL, W_HOST, W_ZERO
  } wsel_t;

  typedef enum logic [1:0] {EA_NONE, EA_PC, EA_ZP, EA_ABS} easel_t;
  typedef enum logic [1:0] {IDX_0, IDX_X, IDX_Y} idx_t;
  typedef enum logic [2:0] {PC_KEEP, PC_EA, PC_Q, PC_QP1, PC_BRANCH} pcsel_t;

  typedef struct packed {
    logic   mem_rd;
    logic   mem_wr;
    asel_t  asel;
    wsel_t  wsel;
    logic   pc_inc;
    logic   lo_load;
    logic   op_load;
    logic   ptr_load;
    easel_t ea_sel;
    idx_t   idx_sel;
    pcsel_t pc_sel;
    logic   sp_inc;
    logic   sp_dec;
    rop_t   reg_op;
    logic   cyc_load;
    logic [2:0] cyc_val;
    logic   cyc_bump;
    logic   cyc_bump_carry;
    logic   unk_set;
    logic   host_load;
    logic   rd_latch;
    logic   out_load;
    logic   clr_inc;
  } cmd_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic       clear_done;
  } sts_t;

  typedef struct packed {
    kind_t      kind;
    mode_t      mode;
    logic [1:0] rsel;
    rop_t       rop;
  } dec_t;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    d.kind = K_UNK;
    d.mode = M_IMM;
    d.rsel = 2'd0;
    d.rop  = R_NONE;
    if (op[1:0] == 2'b01) begin
      case (op[4:2])
        3'd0: d.mode = M_INDX;
        3'd1: d.mode = M_ZP;
        3'd2: d.mode = M_IMM;
        3'd3: d.mode = M_ABS;
        3'd4: d.mode = M_INDY;
        3'd5: d.mode = M_ZPX;
        3'd6: d.mode = M_ABSY;
        default: d.mode = M_ABSX;
      endcase
      case (op[7:5])
        3'd0: d.kind = K_ORA;
        3'd1: d.kind = K_AND;
        3'd2: d.kind = K_EOR;
        3'd4: d.kind = (d.mode == M_IMM) ? K_UNK : K_STORE;
        3'd5: d.kind = K_LOAD;
        default: d.kind = K_UNK;
      endcase
    end else begin
      case (op)
        8'hA2: begin d.kind = K_LOAD;  d.rsel = 2'd1; d.mode = M_IMM;  end
        8'hA6: begin d.kind = K_LOAD;  d.rsel = 2'd1; d.mode = M_ZP;   end
        8'hB6: begin d.kind = K_LOAD;  d.rsel = 2'd1; d.mode = M_ZPY;  end
        8'hAE: begin d.kind = K_LOAD;  d.rsel = 2'd1; d.mode = M_ABS;  end
        8'hBE: begin d.kind = K_LOAD;  d.rsel = 2'd1; d.mode = M_ABSY; end
        8'hA0: begin d.kind = K_LOAD;  d.rsel = 2'd2; d.mode = M_IMM;  end
        8'hA4: begin d.kind = K_LOAD;  d.rsel = 2'd2; d.mode = M_ZP;   end
        8'hB4: begin d.kind = K_LOAD;  d.rsel = 2'd2; d.mode = M_ZPX;  end
        8'hAC: begin d.kind = K_LOAD;  d.rsel = 2'd2; d.mode = M_ABS;  end
        8'hBC: begin d.kind = K_LOAD;  d.rsel = 2'd2; d.mode = M_ABSX; end
        8'h86: begin d.kind = K_STORE; d.rsel = 2'd1; d.mode = M_ZP;   end
        8'h96: begin d.kind = K_STORE; d.rsel = 2'd1; d.mode = M_ZPY;  end
        8'h8E: begin d.kind = K_STORE; d.rsel = 2'd1; d.mode = M_ABS;  end
        8'h84: begin d.kind = K_STORE; d.rsel = 2'd2; d.mode = M_ZP;   end
        8'h94: begin d.kind = K_STORE; d.rsel = 2'd2; d.mode = M_ZPX;  end
        8'h8C: begin d.kind = K_STORE; d.rsel = 2'd2; d.mode = M_ABS;  end
        8'hAA: begin d.kind = K_IMPL; d.rop = R_TAX; end
        8'hA8: begin d.kind = K_IMPL; d.rop = R_TAY; end
        8'h8A: begin d.kind = K_IMPL; d.rop = R_TXA; end
        8'h98: begin d.kind = K_IMPL; d.rop = R_TYA; end
        8'hBA: begin d.kind = K_IMPL; d.rop = R_TSX; end
        8'h9A: begin d.kind = K_IMPL; d.rop = R_TXS; end
        8'hE8: begin d.kind = K_IMPL; d.rop = R_INX; end
        8'hC8: begin d.kind = K_IMPL; d.rop = R_INY; end
        8'hCA: begin d.kind = K_IMPL; d.rop = R_DEX; end
        8'h88: begin d.kind = K_IMPL; d.rop = R_DEY; end
        8'h48: d.kind = K_PHA;
        8'h08: d.kind = K_PHP;
        8'h68: d.kind = K_PLA;
        8'h28: d.kind = K_PLP;
        8'hF0: d.kind = K_BEQ;
        8'h20: d.kind = K_JSR;
        8'h60: d.kind = K_RTS;
        8'h4C: d.kind = K_JMP;
        8'h6C: d.kind = K_JMPI;
        default: d.kind = K_UNK;
      endcase
    end
    return d;
  endfunction

  function automatic logic [2:0] base_cycles(input mode_t m);
    logic [2:0] c;
    case (m)
      M_IMM:  c = 3'd2;
      M_ZP:   c = 3'd3;
      M_INDX: c = 3'd6;
      M_INDY: c = 3'd5;
      default: c = 3'd4;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/cpu6502_dp.sv @@
// ----------------------------------------------------------------------------
// cpu6502_dp
// Register file, address generation, 64 KiB memory and result register.
// ----------------------------------------------------------------------------
module cpu6502_dp #(
  parameter int MEM_BYTES = cpu6502_pkg::MEM_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  cpu6502_pkg::cmd_t  cmd,
  input  logic [15:0]        in_address,
  input  logic [7:0]         in_data,
  output cpu6502_pkg::sts_t  sts,
  output logic [63:0]        out_word
);

  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  q;
  logic [AW:0] clr_cnt;

  logic [15:0] pc;
  logic [7:0]  acc, x, y, sp;
  logic        z, n;
  logic [7:0]  op, lo, ptr;
  logic [15:0] ea;
  logic [15:0] h_addr;
  logic [7:0]  h_data;
  logic [7:0]  rdata;
  logic [2:0]  cyc;
  logic        unk;

  logic [7:0]  idx;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [8:0]  lo_sum;
  logic [15:0] ea_abs;
  logic [15:0] br_pc;
  logic        br_cross;
  logic [7:0]  status_byte;
  logic [7:0]  zp_sum;

  always_comb begin
    case (cmd.idx_sel)
      cpu6502_pkg::IDX_X: idx = x;
      cpu6502_pkg::IDX_Y: idx = y;
      default:            idx = 8'h00;
    endcase
  end

  assign zp_sum      = q + idx;
  assign lo_sum      = {1'b0, lo} + {1'b0, idx};
  assign ea_abs      = {q, lo} + {8'h00, idx};
  assign br_pc       = pc + {{8{q[7]}}, q};
  assign br_cross    = br_pc[15:8] != pc[15:8];
  assign status_byte = {n, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, z, 1'b0};

  always_comb begin
    case (cmd.asel)
      cpu6502_pkg::A_PC:    addr = pc;
      cpu6502_pkg::A_EA:    addr = ea;
      cpu6502_pkg::A_EA1:   addr = ea + 16'd1;
      cpu6502_pkg::A_STACK: addr = {cpu6502_pkg::STACK_PAGE, sp};
      cpu6502_pkg::A_ZPTR:  addr = {8'h00, ptr};
      cpu6502_pkg::A_ZPTR1: addr = {8'h00, ptr + 8'd1};
      cpu6502_pkg::A_HOST:  addr = h_addr;
      default:              addr = 16'(clr_cnt[AW-1:0]);
    endcase
  end

  always_comb begin
    case (cmd.wsel)
      cpu6502_pkg::W_ACC:  wdata = acc;
      cpu6502_pkg::W_X:    wdata = x;
      cpu6502_pkg::W_Y:    wdata = y;
      cpu6502_pkg::W_P:    wdata = status_byte;
      cpu6502_pkg::W_PCH:  wdata = pc[15:8];
      cpu6502_pkg::W_PCL:  wdata = pc[7:0];
      cpu6502_pkg::W_HOST: wdata = h_data;
      default:             wdata = 8'h00;
    endcase
  end

  // single port memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr[AW-1:0]] <= wdata;
    end
    if (cmd.mem_rd) begin
      q <= mem[addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_inc) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sts.opcode     = op;
  assign sts.clear_done = clr_cnt[AW];

  // temporaries
  always_ff @(posedge clk) begin
    if (cmd.op_load) op <= q;
    if (cmd.lo_load) lo <= q;
    if (cmd.ptr_load) ptr <= zp_sum;
    if (cmd.host_load) begin
      h_addr <= in_address;
      h_data <= in_data;
    end
    case (cmd.ea_sel)
      cpu6502_pkg::EA_PC:  ea <= pc;
      cpu6502_pkg::EA_ZP:  ea <= {8'h00, zp_sum};
      cpu6502_pkg::EA_ABS: ea <= ea_abs;
      default: ;
    endcase
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= cpu6502_pkg::PC_RESET;
      acc <= 8'h00;
      x   <= 8'h00;
      y   <= 8'h00;
      sp  <= cpu6502_pkg::SP_RESET;
      z   <= 1'b0;
      n   <= 1'b0;
      cyc <= 3'd0;
      unk <= 1'b0;
      rdata <= 8'h00;
    end else begin
      if (cmd.host_load) begin
        cyc   <= 3'd0;
        unk   <= 1'b0;
        rdata <= 8'h00;
      end
      if (cmd.rd_latch) rdata <= q;
      if (cmd.unk_set) unk <= 1'b1;
      if (cmd.cyc_load) begin
        cyc <= cmd.cyc_val;
      end else if (cmd.cyc_bump || (cmd.cyc_bump_carry && lo_sum[8])) begin
        cyc <= cyc + 3'd1;
      end
      if (cmd.sp_inc) sp <= sp + 8'd1;
      if (cmd.sp_dec) sp <= sp - 8'd1;

      case (cmd.pc_sel)
        cpu6502_pkg::PC_EA:  pc <= ea;
        cpu6502_pkg::PC_Q:   pc <= {q, lo};
        cpu6502_pkg::PC_QP1: pc <= {q, lo} + 16'd1;
        cpu6502_pkg::PC_BRANCH: begin
          if (z) begin
            pc  <= br_pc;
            cyc <= br_cross ? 3'd4 : 3'd3;
          end
        end
        default: begin
          if (cmd.pc_inc) pc <= pc + 16'd1;
        end
      endcase

      case (cmd.reg_op)
        cpu6502_pkg::R_TAX: begin x <= acc; z <= acc == 8'h00; n <= acc[7]; end
        cpu6502_pkg::R_TAY: begin y <= acc; z <= acc == 8'h00; n <= acc[7]; end
        cpu6502_pkg::R_TXA: begin acc <= x; z <= x == 8'h00; n <= x[7]; end
        cpu6502_pkg::R_TYA: begin acc <= y; z <= y == 8'h00; n <= y[7]; end
        cpu6502_pkg::R_TSX: begin x <= sp; z <= sp == 8'h00; n <= sp[7]; end
        cpu6502_pkg::R_TXS: sp <= x;
        cpu6502_pkg::R_INX: begin
          x <= x + 8'd1; z <= (x + 8'd1) == 8'h00; n <= x[7] ^ (&x[6:0]);
        end
        cpu6502_pkg::R_INY: begin
          y <= y + 8'd1; z <= (y + 8'd1) == 8'h00; n <= y[7] ^ (&y[6:0]);
        end
        cpu6502_pkg::R_DEX: begin
          x <= x - 8'd1; z <= x == 8'h01; n <= x[7] ^ (x[6:0] == 7'h00);
        end
        cpu6502_pkg::R_DEY: begin
          y <= y - 8'd1; z <= y == 8'h01; n <= y[7] ^ (y[6:0] == 7'h00);
        end
        cpu6502_pkg::R_LDA, cpu6502_pkg::R_PLA: begin
          acc <= q; z <= q == 8'h00; n <= q[7];
        end
        cpu6502_pkg::R_LDX: begin x <= q; z <= q == 8'h00; n <= q[7]; end
        cpu6502_pkg::R_LDY: begin y <= q; z <= q == 8'h00; n <= q[7]; end
        cpu6502_pkg::R_ORA: begin
          acc <= acc | q; z <= (acc | q) == 8'h00; n <= acc[7] | q[7];
        end
        cpu6502_pkg::R_AND: begin
          acc <= acc & q; z <= (acc & q) == 8'h00; n <= acc[7] & q[7];
        end
        cpu6502_pkg::R_EOR: begin
          acc <= acc ^ q; z <= (acc ^ q) == 8'h00; n <= acc[7] ^ q[7];
        end
        cpu6502_pkg::R_PLP: begin n <= q[7]; z <= q[1]; end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word <= {2'b00, unk, cyc, n, z, sp, y, x, acc, pc, rdata};
    end
  end

endmodule

@@ hw/rtl/cpu6502_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpu6502_ctrl
// Sequencer: memory clear, host accesses and instruction micro-steps.
// ----------------------------------------------------------------------------
module cpu6502_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic [1:0]         s_action,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  cpu6502_pkg::sts_t  sts,
  output cpu6502_pkg::cmd_t  cmd
);

  cpu6502_pkg::state_t state, state_next;
  cpu6502_pkg::dec_t   dec;
  logic                accept;
  logic                slot_free;
  logic                indexed;

  assign dec       = cpu6502_pkg::decode(sts.opcode);
  assign s_tready  = state == cpu6502_pkg::ST_IDLE;
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign indexed   = dec.mode == cpu6502_pkg::M_ABSX || dec.mode == cpu6502_pkg::M_ABSY
                     || dec.mode == cpu6502_pkg::M_INDY;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cpu6502_pkg::ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cpu6502_pkg::ST_CLEAR: if (sts.clear_done) state_next = cpu6502_pkg::ST_IDLE;
      cpu6502_pkg::ST_IDLE: begin
        if (accept) begin
          case (s_action)
            cpu6502_pkg::ACT_WRITE: state_next = cpu6502_pkg::ST_HWR;
            cpu6502_pkg::ACT_READ:  state_next = cpu6502_pkg::ST_HRD;
            cpu6502_pkg::ACT_EXEC:  state_next = cpu6502_pkg::ST_FETCH;
            default:                state_next = cpu6502_pkg::ST_DONE;
          endcase
        end
      end
      cpu6502_pkg::ST_HWR:      state_next = cpu6502_pkg::ST_DONE;
      cpu6502_pkg::ST_HRD:      state_next = cpu6502_pkg::ST_HRD_WAIT;
      cpu6502_pkg::ST_HRD_WAIT: state_next = cpu6502_pkg::ST_DONE;
      cpu6502_pkg::ST_FETCH:    state_next = cpu6502_pkg::ST_OPC;
      cpu6502_pkg::ST_OPC:      state_next = cpu6502_pkg::ST_DECODE;
      cpu6502_pkg::ST_DECODE: begin
        case (dec.kind)
          cpu6502_pkg::K_LOAD, cpu6502_pkg::K_STORE, cpu6502_pkg::K_ORA,
          cpu6502_pkg::K_AND, cpu6502_pkg::K_EOR:
            state_next = (dec.mode == cpu6502_pkg::M_IMM) ? cpu6502_pkg::ST_OPER
                                                          : cpu6502_pkg::ST_AD2;
          cpu6502_pkg::K_PLA, cpu6502_pkg::K_PLP: state_next = cpu6502_pkg::ST_PULL;
          cpu6502_pkg::K_BEQ:  state_next = cpu6502_pkg::ST_BR;
          cpu6502_pkg::K_JSR:  state_next = cpu6502_pkg::ST_JSR2;
          cpu6502_pkg::K_RTS:  state_next = cpu6502_pkg::ST_RTS1;
          cpu6502_pkg::K_JMP, cpu6502_pkg::K_JMPI: state_next = cpu6502_pkg::ST_JMP2;
          default: state_next = cpu6502_pkg::ST_DONE;
        endcase
      end
      cpu6502_pkg::ST_AD2: begin
        case (dec.mode)
          cpu6502_pkg::M_ZP, cpu6502_pkg::M_ZPX, cpu6502_pkg::M_ZPY:
            state_next = cpu6502_pkg::ST_OPER;
          cpu6502_pkg::M_INDX, cpu6502_pkg::M_INDY: state_next = cpu6502_pkg::ST_PTR1;
          default: state_next = cpu6502_pkg::ST_AD3;
        endcase
      end
      cpu6502_pkg::ST_AD3:  state_next = cpu6502_pkg::ST_OPER;
      cpu6502_pkg::ST_PTR1: state_next = cpu6502_pkg::ST_PTR2;
      cpu6502_pkg::ST_PTR2: state_next = cpu6502_pkg::ST_AD3;
      cpu6502_pkg::ST_OPER:
        state_next = (dec.kind == cpu6502_pkg::K_STORE) ? cpu6502_pkg::ST_DONE
                                                        : cpu6502_pkg::ST_EXEC;
      cpu6502_pkg::ST_EXEC:      state_next = cpu6502_pkg::ST_DONE;
      cpu6502_pkg::ST_PULL:      state_next = cpu6502_pkg::ST_PULL_EXEC;
      cpu6502_pkg::ST_PULL_EXEC: state_next = cpu6502_pkg::ST_DONE;
      cpu6502_pkg::ST_BR:        state_next = cpu6502_pkg::ST_DONE;
      cpu6502_pkg::ST_JSR2:      state_next = cpu6502_pkg::ST_JSR3;
      cpu6502_pkg::ST_JSR3:      state_next = cpu6502_pkg::ST_JSR4;
      cpu6502_pkg::ST_JSR4:      state_next = cpu6502_pkg::ST_DONE;
      cpu6502_pkg::ST_RTS1:      state_next = cpu6502_pkg::ST_RTS2;
      cpu6502_pkg::ST_RTS2:      state_next = cpu6502_pkg::ST_RTS3;
      cpu6502_pkg::ST_RTS3:      state_next = cpu6502_pkg::ST_DONE;
      cpu6502_pkg::ST_JMP2:      state_next = cpu6502_pkg::ST_JMP3;
      cpu6502_pkg::ST_JMP3:
        state_next = (dec.kind == cpu6502_pkg::K_JMPI) ? cpu6502_pkg::ST_JI1
                                                       : cpu6502_pkg::ST_DONE;
      cpu6502_pkg::ST_JI1: state_next = cpu6502_pkg::ST_JI2;
      cpu6502_pkg::ST_JI2: state_next = cpu6502_pkg::ST_JI3;
      cpu6502_pkg::ST_JI3: state_next = cpu6502_pkg::ST_DONE;
      cpu6502_pkg::ST_DONE: if (slot_free) state_next = cpu6502_pkg::ST_IDLE;
      default: state_next = cpu6502_pkg::ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.asel    = cpu6502_pkg::A_PC;
    cmd.wsel    = cpu6502_pkg::W_ZERO;
    cmd.ea_sel  = cpu6502_pkg::EA_NONE;
    cmd.idx_sel = cpu6502_pkg::IDX_0;
    cmd.pc_sel  = cpu6502_pkg::PC_KEEP;
    cmd.reg_op  = cpu6502_pkg::R_NONE;
    case (state)
      cpu6502_pkg::ST_CLEAR: begin
        cmd.asel = cpu6502_pkg::A_CLR;
        if (!sts.clear_done) begin
          cmd.mem_wr  = 1'b1;
          cmd.clr_inc = 1'b1;
        end
      end
      cpu6502_pkg::ST_IDLE: cmd.host_load = accept;
      cpu6502_pkg::ST_HWR: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = cpu6502_pkg::A_HOST;
        cmd.wsel   = cpu6502_pkg::W_HOST;
      end
      cpu6502_pkg::ST_HRD: begin
        cmd.mem_rd = 1'b1;
        cmd.asel   = cpu6502_pkg::A_HOST;
      end
      cpu6502_pkg::ST_HRD_WAIT: cmd.rd_latch = 1'b1;
      cpu6502_pkg::ST_FETCH: begin
        cmd.mem_rd = 1'b1;
        cmd.pc_inc = 1'b1;
      end
      cpu6502_pkg::ST_OPC: cmd.op_load = 1'b1;
      cpu6502_pkg::ST_DECODE: begin
        cmd.cyc_load = 1'b1;
        cmd.cyc_val  = 3'd2;
        case (dec.kind)
          cpu6502_pkg::K_LOAD, cpu6502_pkg::K_STORE, cpu6502_pkg::K_ORA,
          cpu6502_pkg::K_AND, cpu6502_pkg::K_EOR: begin
            cmd.cyc_val = cpu6502_pkg::base_cycles(dec.mode);
            cmd.pc_inc  = 1'b1;
            if (dec.mode == cpu6502_pkg::M_IMM) begin
              cmd.ea_sel = cpu6502_pkg::EA_PC;
            end else begin
              cmd.mem_rd = 1'b1;
            end
          end
          cpu6502_pkg::K_IMPL: cmd.reg_op = dec.rop;
          cpu6502_pkg::K_PHA, cpu6502_pkg::K_PHP: begin
            cmd.cyc_val = 3'd3;
            cmd.mem_wr  = 1'b1;
            cmd.asel    = cpu6502_pkg::A_STACK;
            cmd.wsel    = (dec.kind == cpu6502_pkg::K_PHA) ? cpu6502_pkg::W_ACC
                                                           : cpu6502_pkg::W_P;
            cmd.sp_dec  = 1'b1;
          end
          cpu6502_pkg::K_PLA, cpu6502_pkg::K_PLP: begin
            cmd.cyc_val = 3'd4;
            cmd.sp_inc  = 1'b1;
          end
          cpu6502_pkg::K_BEQ: begin
            cmd.mem_rd = 1'b1;
            cmd.pc_inc = 1'b1;
          end
          cpu6502_pkg::K_JSR: begin
            cmd.cyc_val = 3'd6;
            cmd.mem_rd  = 1'b1;
            cmd.pc_inc  = 1'b1;
          end
          cpu6502_pkg::K_RTS: begin
            cmd.cyc_val = 3'd6;
            cmd.sp_inc  = 1'b1;
          end
          cpu6502_pkg::K_JMP, cpu6502_pkg::K_JMPI: begin
            cmd.cyc_val = (dec.kind == cpu6502_pkg::K_JMP) ? 3'd3 : 3'd5;
            cmd.mem_rd  = 1'b1;
            cmd.pc_inc  = 1'b1;
          end
          default: cmd.unk_set = 1'b1;
        endcase
      end
      cpu6502_pkg::ST_AD2: begin
        case (dec.mode)
          cpu6502_pkg::M_ZP: cmd.ea_sel = cpu6502_pkg::EA_ZP;
          cpu6502_pkg::M_ZPX: begin
            cmd.ea_sel  = cpu6502_pkg::EA_ZP;
            cmd.idx_sel = cpu6502_pkg::IDX_X;
          end
          cpu6502_pkg::M_ZPY: begin
            cmd.ea_sel  = cpu6502_pkg::EA_ZP;
            cmd.idx_sel = cpu6502_pkg::IDX_Y;
          end
          cpu6502_pkg::M_INDX: begin
            cmd.ptr_load = 1'b1;
            cmd.idx_sel  = cpu6502_pkg::IDX_X;
          end
          cpu6502_pkg::M_INDY: cmd.ptr_load = 1'b1;
          default: begin
            cmd.lo_load = 1'b1;
            cmd.mem_rd  = 1'b1;
            cmd.pc_inc  = 1'b1;
          end
        endcase
      end
      cpu6502_pkg::ST_PTR1: begin
        cmd.mem_rd = 1'b1;
        cmd.asel   = cpu6502_pkg::A_ZPTR;
      end
      cpu6502_pkg::ST_PTR2: begin
        cmd.lo_load = 1'b1;
        cmd.mem_rd  = 1'b1;
        cmd.asel    = cpu6502_pkg::A_ZPTR1;
      end
      cpu6502_pkg::ST_AD3: begin
        cmd.ea_sel = cpu6502_pkg::EA_ABS;
        if (dec.mode == cpu6502_pkg::M_ABSX) begin
          cmd.idx_sel = cpu6502_pkg::IDX_X;
        end else if (indexed) begin
          cmd.idx_sel = cpu6502_pkg::IDX_Y;
        end
        cmd.cyc_bump_carry = indexed;
        cmd.cyc_bump       = indexed && dec.kind == cpu6502_pkg::K_STORE;
      end
      cpu6502_pkg::ST_OPER: begin
        cmd.asel = cpu6502_pkg::A_EA;
        if (dec.kind == cpu6502_pkg::K_STORE) begin
          cmd.mem_wr = 1'b1;
          case (dec.rsel)
            2'd1:    cmd.wsel = cpu6502_pkg::W_X;
            2'd2:    cmd.wsel = cpu6502_pkg::W_Y;
            default: cmd.wsel = cpu6502_pkg::W_ACC;
          endcase
        end else begin
          cmd.mem_rd = 1'b1;
        end
      end
      cpu6502_pkg::ST_EXEC: begin
        case (dec.kind)
          cpu6502_pkg::K_ORA: cmd.reg_op = cpu6502_pkg::R_ORA;
          cpu6502_pkg::K_AND: cmd.reg_op = cpu6502_pkg::R_AND;
          cpu6502_pkg::K_EOR: cmd.reg_op = cpu6502_pkg::R_EOR;
          default: begin
            case (dec.rsel)
              2'd1:    cmd.reg_op = cpu6502_pkg::R_LDX;
              2'd2:    cmd.reg_op = cpu6502_pkg::R_LDY;
              default: cmd.reg_op = cpu6502_pkg::R_LDA;
            endcase
          end
        endcase
      end
      cpu6502_pkg::ST_PULL: begin
        cmd.mem_rd = 1'b1;
        cmd.asel   = cpu6502_pkg::A_STACK;
      end
      cpu6502_pkg::ST_PULL_EXEC:
        cmd.reg_op = (dec.kind == cpu6502_pkg::K_PLA) ? cpu6502_pkg::R_PLA
                                                      : cpu6502_pkg::R_PLP;
      cpu6502_pkg::ST_BR: cmd.pc_sel = cpu6502_pkg::PC_BRANCH;
      cpu6502_pkg::ST_JSR2: begin
        cmd.lo_load = 1'b1;
        cmd.mem_rd  = 1'b1;
      end
      cpu6502_pkg::ST_JSR3: begin
        cmd.ea_sel = cpu6502_pkg::EA_ABS;
        cmd.mem_wr = 1'b1;
        cmd.asel   = cpu6502_pkg::A_STACK;
        cmd.wsel   = cpu6502_pkg::W_PCH;
        cmd.sp_dec = 1'b1;
      end
      cpu6502_pkg::ST_JSR4: begin
        cmd.mem_wr = 1'b1;
        cmd.asel   = cpu6502_pkg::A_STACK;
        cmd.wsel   = cpu6502_pkg::W_PCL;
        cmd.sp_dec = 1'b1;
        cmd.pc_sel = cpu6502_pkg::PC_EA;
      end
      cpu6502_pkg::ST_RTS1: begin
        cmd.mem_rd = 1'b1;
        cmd.asel   = cpu6502_pkg::A_STACK;
        cmd.sp_inc = 1'b1;
      end
      cpu6502_pkg::ST_RTS2: begin
        cmd.lo_load = 1'b1;
        cmd.mem_rd  = 1'b1;
        cmd.asel    = cpu6502_pkg::A_STACK;
      end
      cpu6502_pkg::ST_RTS3: cmd.pc_sel = cpu6502_pkg::PC_QP1;
      cpu6502_pkg::ST_JMP2: begin
        cmd.lo_load = 1'b1;
        cmd.mem_rd  = 1'b1;
        cmd.pc_inc  = 1'b1;
      end
      cpu6502_pkg::ST_JMP3: begin
        if (dec.kind == cpu6502_pkg::K_JMPI) begin
          cmd.ea_sel = cpu6502_pkg::EA_ABS;
        end else begin
          cmd.pc_sel = cpu6502_pkg::PC_Q;
        end
      end
      cpu6502_pkg::ST_JI1: begin
        cmd.mem_rd = 1'b1;
        cmd.asel   = cpu6502_pkg::A_EA;
      end
      cpu6502_pkg::ST_JI2: begin
        cmd.lo_load = 1'b1;
        cmd.mem_rd  = 1'b1;
        cmd.asel    = cpu6502_pkg::A_EA1;
      end
      cpu6502_pkg::ST_JI3: cmd.pc_sel = cpu6502_pkg::PC_Q;
      cpu6502_pkg::ST_DONE: cmd.out_load = slot_free;
      default: ;
    endcase
  end

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("memory read and write in one cycle");

  a_clear_addr: assert property (@(posedge clk) disable iff (rst)
    (state == cpu6502_pkg::ST_CLEAR && cmd.mem_wr) |-> cmd.asel == cpu6502_pkg::A_CLR)
    else $error("clearing pass writes off its sweep");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwrites an untaken word");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second word taken while busy");

endmodule

@@ hw/rtl/cpu6502_subset_core_top.sv @@
// ----------------------------------------------------------------------------
// cpu_6502_subset_core_top
// 6502 subset core with a private 64 KiB memory behind a stream interface.
// ----------------------------------------------------------------------------
// After reset the core sweeps all MEM_BYTES bytes of its memory to zero, one
// byte per clock, and accepts no word until the sweep ends. Each word is
// then handled alone, in micro-steps around the single port memory that
// makes one access per clock with registered read data. A finished result
// sits in an output register, so the next word is taken while it waits.
module cpu_6502_subset_core_top #(
  parameter int MEM_BYTES = cpu6502_pkg::MEM_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // action[1:0], address[17:2], data[25:18]
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], program_counter[23:8], accumulator[31:24], index_x[39:32],
  // index_y[47:40], stack_pointer[55:48], zero_out[56], negative_out[57],
  // cycles_used[60:58], unknown_opcode[61]
  output logic [63:0] m_tdata
);

  cpu6502_pkg::cmd_t cmd;
  cpu6502_pkg::sts_t sts;

  cpu6502_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_action (s_tdata[1:0]),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpu6502_dp #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_address (s_tdata[17:2]),
    .in_data    (s_tdata[25:18]),
    .sts        (sts),
    .out_word   (m_tdata)
  );

endmodule

@@ tb/cpu_6502_subset_core_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu_6502_subset_core_top_tb
// Drives memory writes, reads and instruction steps into the 6502 subset core
// and checks every result word against a behavioural model of the core kept
// in the bench, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module cpu_6502_subset_core_top_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  typedef struct packed {
    logic       unk;
    logic [2:0] cyc;
    logic       n;
    logic       z;
    logic [7:0] sp;
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] a;
    logic [15:0] pc;
    logic [7:0] rdata;
  } cpu_result_t;

  localparam int WATCHDOG = 200000;

  logic [7:0]  mem [0:65535];
  logic [15:0] pc;
  logic [7:0]  ra, rx, ry, rsp;
  logic        fz, fn;

  cpu_result_t expected_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          done = 1'b0;

  cpu_6502_subset_core_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] fetch();
    logic [7:0] v;
    v = mem[pc];
    pc = pc + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] fetch_word();
    logic [7:0] lo;
    lo = fetch();
    return {fetch(), lo};
  endfunction

  function automatic void set_flags(input logic [7:0] v);
    fz = (v == 8'h00);
    fn = v[7];
  endfunction

  function automatic void push(input logic [7:0] v);
    mem[{cpu6502_pkg::STACK_PAGE, rsp}] = v;
    rsp = rsp - 8'd1;
  endfunction

  function automatic logic [7:0] pull();
    rsp = rsp + 8'd1;
    return mem[{cpu6502_pkg::STACK_PAGE, rsp}];
  endfunction

  function automatic logic [15:0] zp_ptr(input logic [7:0] p);
    return {mem[{8'h00, p + 8'd1}], mem[{8'h00, p}]};
  endfunction

  function automatic logic [15:0] operand_addr(input cpu6502_pkg::mode_t m, input bit st,
                                               output logic [2:0] cyc);
    logic [15:0] b, ea;
    logic [7:0] z;
    case (m)
      cpu6502_pkg::M_IMM: begin ea = pc; pc = pc + 16'd1; cyc = 3'd2; end
      cpu6502_pkg::M_ZP: begin ea = {8'h00, fetch()}; cyc = 3'd3; end
      cpu6502_pkg::M_ZPX: begin z = fetch() + rx; ea = {8'h00, z}; cyc = 3'd4; end
      cpu6502_pkg::M_ZPY: begin z = fetch() + ry; ea = {8'h00, z}; cyc = 3'd4; end
      cpu6502_pkg::M_ABS: begin ea = fetch_word(); cyc = 3'd4; end
      cpu6502_pkg::M_ABSX, cpu6502_pkg::M_ABSY: begin
        b = fetch_word();
        ea = b + ((m == cpu6502_pkg::M_ABSX) ? {8'h00, rx} : {8'h00, ry});
        cyc = (st || ea[15:8] != b[15:8]) ? 3'd5 : 3'd4;
      end
      cpu6502_pkg::M_INDX: begin ea = zp_ptr(fetch() + rx); cyc = 3'd6; end
      default: begin
        b = zp_ptr(fetch());
        ea = b + {8'h00, ry};
        cyc = (st || ea[15:8] != b[15:8]) ? 3'd6 : 3'd5;
      end
    endcase
    return ea;
  endfunction

  function automatic void run_instruction(output logic [2:0] cyc, output logic unk);
    logic [7:0] op, v, off;
    logic [15:0] t, np;
    cpu6502_pkg::mode_t m;
    cyc = 3'd2;
    unk = 1'b0;
    op = fetch();
    if (op[1:0] == 2'b01) begin
      case (op[4:2])
        3'd0: m = cpu6502_pkg::M_INDX;
        3'd1: m = cpu6502_pkg::M_ZP;
        3'd2: m = cpu6502_pkg::M_IMM;
        3'd3: m = cpu6502_pkg::M_ABS;
        3'd4: m = cpu6502_pkg::M_INDY;
        3'd5: m = cpu6502_pkg::M_ZPX;
        3'd6: m = cpu6502_pkg::M_ABSY;
        default: m = cpu6502_pkg::M_ABSX;
      endcase
      if (op[7:5] == 3'd5) begin
        ra = mem[operand_addr(m, 1'b0, cyc)];
        set_flags(ra);
      end else if (op[7:5] == 3'd4 && m != cpu6502_pkg::M_IMM) begin
        mem[operand_addr(m, 1'b1, cyc)] = ra;
      end else if (op[7:5] <= 3'd2) begin
        v = mem[operand_addr(m, 1'b0, cyc)];
        case (op[7:5])
          3'd0: ra = ra | v;
          3'd1: ra = ra & v;
          default: ra = ra ^ v;
        endcase
        set_flags(ra);
      end else begin
        unk = 1'b1;
      end
      return;
    end
    case (op)
      8'hA2: begin rx = mem[operand_addr(cpu6502_pkg::M_IMM, 1'b0, cyc)]; set_flags(rx); end
      8'hA6: begin rx = mem[operand_addr(cpu6502_pkg::M_ZP, 1'b0, cyc)]; set_flags(rx); end
      8'hB6: begin rx = mem[operand_addr(cpu6502_pkg::M_ZPY, 1'b0, cyc)]; set_flags(rx); end
      8'hAE: begin rx = mem[operand_addr(cpu6502_pkg::M_ABS, 1'b0, cyc)]; set_flags(rx); end
      8'hBE: begin rx = mem[operand_addr(cpu6502_pkg::M_ABSY, 1'b0, cyc)]; set_flags(rx); end
      8'hA0: begin ry = mem[operand_addr(cpu6502_pkg::M_IMM, 1'b0, cyc)]; set_flags(ry); end
      8'hA4: begin ry = mem[operand_addr(cpu6502_pkg::M_ZP, 1'b0, cyc)]; set_flags(ry); end
      8'hB4: begin ry = mem[operand_addr(cpu6502_pkg::M_ZPX, 1'b0, cyc)]; set_flags(ry); end
      8'hAC: begin ry = mem[operand_addr(cpu6502_pkg::M_ABS, 1'b0, cyc)]; set_flags(ry); end
      8'hBC: begin ry = mem[operand_addr(cpu6502_pkg::M_ABSX, 1'b0, cyc)]; set_flags(ry); end
      8'h86: mem[operand_addr(cpu6502_pkg::M_ZP, 1'b1, cyc)] = rx;
      8'h96: mem[operand_addr(cpu6502_pkg::M_ZPY, 1'b1, cyc)] = rx;
      8'h8E: mem[operand_addr(cpu6502_pkg::M_ABS, 1'b1, cyc)] = rx;
      8'h84: mem[operand_addr(cpu6502_pkg::M_ZP, 1'b1, cyc)] = ry;
      8'h94: mem[operand_addr(cpu6502_pkg::M_ZPX, 1'b1, cyc)] = ry;
      8'h8C: mem[operand_addr(cpu6502_pkg::M_ABS, 1'b1, cyc)] = ry;
      8'hAA: begin rx = ra; set_flags(rx); end
      8'hA8: begin ry = ra; set_flags(ry); end
      8'h8A: begin ra = rx; set_flags(ra); end
      8'h98: begin ra = ry; set_flags(ra); end
      8'hBA: begin rx = rsp; set_flags(rx); end
      8'h9A: rsp = rx;
      8'hE8: begin rx = rx + 8'd1; set_flags(rx); end
      8'hC8: begin ry = ry + 8'd1; set_flags(ry); end
      8'hCA: begin rx = rx - 8'd1; set_flags(rx); end
      8'h88: begin ry = ry - 8'd1; set_flags(ry); end
      8'h48: begin push(ra); cyc = 3'd3; end
      8'h08: begin push({fn, 5'b01100, fz, 1'b0}); cyc = 3'd3; end
      8'h68: begin ra = pull(); set_flags(ra); cyc = 3'd4; end
      8'h28: begin v = pull(); fn = v[7]; fz = v[1]; cyc = 3'd4; end
      8'hF0: begin
        off = fetch();
        if (fz) begin
          np = pc + {{8{off[7]}}, off};
          cyc = (np[15:8] != pc[15:8]) ? 3'd4 : 3'd3;
          pc = np;
        end
      end
      8'h20: begin
        t = fetch_word();
        np = pc - 16'd1;
        push(np[15:8]);
        push(np[7:0]);
        pc = t;
        cyc = 3'd6;
      end
      8'h60: begin
        t[7:0] = pull();
        t[15:8] = pull();
        pc = t + 16'd1;
        cyc = 3'd6;
      end
      8'h4C: begin pc = fetch_word(); cyc = 3'd3; end
      8'h6C: begin
        t = fetch_word();
        pc = {mem[t + 16'd1], mem[t]};
        cyc = 3'd5;
      end
      default: unk = 1'b1;
    endcase
  endfunction

  function automatic cpu_result_t predict_step(input logic [1:0] act,
                                               input logic [15:0] addr,
                                               input logic [7:0] data);
    cpu_result_t r;
    logic [2:0] cyc;
    logic unk;
    r = '0;
    cyc = 3'd0;
    unk = 1'b0;
    if (act == cpu6502_pkg::ACT_WRITE) mem[addr] = data;
    else if (act == cpu6502_pkg::ACT_READ) r.rdata = mem[addr];
    else if (act == cpu6502_pkg::ACT_EXEC) run_instruction(cyc, unk);
    r.pc = pc; r.a = ra; r.x = rx; r.y = ry; r.sp = rsp;
    r.z = fz; r.n = fn; r.cyc = cyc; r.unk = unk;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_word(input logic [1:0] act, input logic [15:0] addr,
                           input logic [7:0] data);
    int gap;
    gap = 1;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(2, 4);
    end
    repeat (gap) @(posedge clk);
    expected_q.push_back(predict_step(act, addr, data));
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, data, addr, act};
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
  endtask

  task automatic poke(input logic [15:0] addr, input logic [7:0] data);
    send_word(cpu6502_pkg::ACT_WRITE, addr, data);
  endtask

  task automatic step();
    send_word(cpu6502_pkg::ACT_EXEC, 16'($urandom), 8'($urandom));
  endtask

  task automatic load_program(input logic [15:0] org, input logic [7:0] bytes[$]);
    foreach (bytes[i]) poke(org + i[15:0], bytes[i]);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // directed: extremes, every kind, wraps, page crossing, status byte
  task automatic test_directed();
    send_word(cpu6502_pkg::ACT_READ, 16'hFFFF, 8'hFF);
    poke(16'hFFFF, 8'hFF);
    send_word(cpu6502_pkg::ACT_READ, 16'hFFFF, 8'h00);
    poke(16'hFFFC, 8'h4C);
    poke(16'hFFFD, 8'h00);
    poke(16'hFFFE, 8'h02);
    step();
    load_program(16'h0200, '{8'hA9, 8'h80, 8'hA2, 8'hFF, 8'hB5, 8'h05,
                             8'h08, 8'h28, 8'hBD, 8'h01, 8'h02, 8'hF0, 8'h80,
                             8'h03, 8'hFF});
    repeat (7) step();
    drain();
    send_word(cpu6502_pkg::ACT_NOP, 16'h1234, 8'h56);
  endtask

  task automatic test_subroutine();
    load_program(16'h0300, '{8'h20, 8'h10, 8'h03, 8'h6C, 8'hFF, 8'h30});
    load_program(16'h0310, '{8'h48, 8'h68, 8'h60});
    poke(16'h30FF, 8'h00);
    poke(16'h3100, 8'h03);
    // jump from wherever the core stands into the subroutine test
    poke(pc, 8'h4C);
    poke(pc + 16'd1, 8'h00);
    poke(pc + 16'd2, 8'h03);
    step();
    repeat (6) step();
  endtask

  function automatic logic [7:0] random_opcode();
    logic [7:0] known[$] = '{8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE, 8'hA0, 8'hA4,
      8'hB4, 8'hAC, 8'hBC, 8'h86, 8'h96, 8'h8E, 8'h84, 8'h94, 8'h8C, 8'hAA,
      8'hA8, 8'h8A, 8'h98, 8'hBA, 8'h9A, 8'hE8, 8'hC8, 8'hCA, 8'h88, 8'h48,
      8'h08, 8'h68, 8'h28, 8'hF0, 8'h20, 8'h60, 8'h4C, 8'h6C};
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return {$urandom_range(0, 2) == 2 ? 3'd5 : 3'($urandom_range(0, 5)),
                       3'($urandom), 2'b01};
    if (k < 9) return known[$urandom_range(0, known.size() - 1)];
    return 8'($urandom);
  endfunction

  // short random programs, mostly in one working region, then executed
  task automatic test_random_programs(input int n_items);
    int sent;
    logic [15:0] org;
    sent = 0;
    while (sent < n_items) begin
      org = ($urandom_range(0, 7) == 0) ? 16'($urandom) : {8'h04, 8'($urandom)};
      poke(16'hFFF0, 8'h4C);
      poke(16'hFFF1, org[7:0]);
      poke(16'hFFF2, org[15:8]);
      for (int i = 0; i < 6; i++) begin
        poke(org + 16'(3 * i), random_opcode());
        poke(org + 16'(3 * i + 1), ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                                               : 8'($urandom));
        poke(org + 16'(3 * i + 2), ($urandom_range(0, 1) == 0) ? 8'h04 : 8'($urandom));
      end
      for (int i = 0; i < 8; i++) poke({8'h00, 8'($urandom)}, 8'($urandom));
      send_word(cpu6502_pkg::ACT_READ, 16'($urandom), 8'($urandom));
      sent += 30;
      if (pc != 16'hFFF0 && $urandom_range(0, 3) != 0) begin
        poke(pc, 8'h4C);
        poke(pc + 16'd1, 8'hF0);
        poke(pc + 16'd2, 8'hFF);
        step();
        sent += 4;
      end
      for (int i = 0; i < 8; i++) step();
      sent += 8;
    end
  endtask

  // receiver holds off while words keep coming, then sender waits for drain
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_word(cpu6502_pkg::ACT_READ, 16'($urandom), 8'h00);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 65536; i++) mem[i] = 8'h00;
    pc = cpu6502_pkg::PC_RESET; ra = 8'h00; rx = 8'h00; ry = 8'h00;
    rsp = cpu6502_pkg::SP_RESET; fz = 1'b0; fn = 1'b0;
    test_directed();
    test_subroutine();
    test_backpressure();
    test_random_programs(400);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_off) begin
      m_tready <= 1'b0;
      idle_cycles = idle_cycles + 1;
      if (idle_cycles > 200) begin
        hold_off = 1'b0;
        idle_cycles = 0;
      end
    end else if ($urandom_range(0, 9) < 2) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cpu_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[61:0];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", got.pc, 16'h0000);
      end else begin
        want = expected_q.pop_front();
        if (got.rdata !== want.rdata)
          report_mismatch("read_data", 16'(got.rdata), 16'(want.rdata));
        if (got.pc !== want.pc) report_mismatch("program_counter", got.pc, want.pc);
        if (got.a !== want.a) report_mismatch("accumulator", 16'(got.a), 16'(want.a));
        if (got.x !== want.x) report_mismatch("index_x", 16'(got.x), 16'(want.x));
        if (got.y !== want.y) report_mismatch("index_y", 16'(got.y), 16'(want.y));
        if (got.sp !== want.sp)
          report_mismatch("stack_pointer", 16'(got.sp), 16'(want.sp));
        if (got.z !== want.z) report_mismatch("zero_out", 16'(got.z), 16'(want.z));
        if (got.n !== want.n) report_mismatch("negative_out", 16'(got.n), 16'(want.n));
        if (got.cyc !== want.cyc)
          report_mismatch("cycles_used", 16'(got.cyc), 16'(want.cyc));
        if (got.unk !== want.unk)
          report_mismatch("unknown_opcode", 16'(got.unk), 16'(want.unk));
      end
    end
  end

  // stall watchdog, allows for the memory sweep after reset
  int stalled = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled <= 0;
    else stalled <= stalled + 1;
    if (stalled > 65536 + WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
